FILE: sv/ads_pkg.sv
// Shared types and constants for the advertising-data service filter.
package ads_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_UUID_LOW    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_UUID_HIGH   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MFR_PATTERN = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_MFR_LEN     = 2'd3;
  localparam int unsigned CfgDataW = 64;

  // Register reset values and limits
  localparam logic [47:0] MFR_PATTERN_RESET = 48'h00EE_FFC0_000D;
  localparam logic [2:0]  MFR_LEN_RESET     = 3'd6;
  localparam logic [2:0]  MFR_MAX           = 3'd6;

  // Structure type codes
  localparam logic [7:0] TYPE_UUID128_MORE = 8'h06;
  localparam logic [7:0] TYPE_UUID128_ALL  = 8'h07;
  localparam logic [7:0] TYPE_MFR          = 8'hFF;

  // Parser phase
  typedef enum logic [1:0] {
    PH_LEN,
    PH_TYPE,
    PH_DATA
  } phase_t;

  // Class of the structure being parsed
  typedef enum logic [1:0] {
    KIND_OTHER,
    KIND_UUID,
    KIND_MFR
  } kind_t;

  // Configuration handed to the parser
  typedef struct packed {
    logic [127:0] uuid;
    logic [47:0]  mfr_pattern;
    logic [2:0]   mfr_len;
  } cfg_t;

  // Match flags after the current byte
  typedef struct packed {
    logic uuid_hit;
    logic mfr_hit;
  } flags_t;

endpackage

FILE: sv/ads_cfg.sv
// Configuration register file of the advertising-data service filter.
module ads_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ads_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [ads_pkg::CfgDataW-1:0]        cfg_wdata,
  output ads_pkg::cfg_t                       cfg
);

  logic [63:0] uuid_low_r;
  logic [63:0] uuid_high_r;
  logic [47:0] mfr_pattern_r;
  logic [2:0]  mfr_len_r;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uuid_low_r    <= '0;
      uuid_high_r   <= '0;
      mfr_pattern_r <= ads_pkg::MFR_PATTERN_RESET;
      mfr_len_r     <= ads_pkg::MFR_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ads_pkg::CFG_UUID_LOW:    uuid_low_r    <= cfg_wdata;
        ads_pkg::CFG_UUID_HIGH:   uuid_high_r   <= cfg_wdata;
        ads_pkg::CFG_MFR_PATTERN: mfr_pattern_r <= cfg_wdata[47:0];
        ads_pkg::CFG_MFR_LEN:     mfr_len_r     <= cfg_wdata[2:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.uuid        = {uuid_high_r, uuid_low_r};
  assign cfg.mfr_pattern = mfr_pattern_r;
  assign cfg.mfr_len     = mfr_len_r;

endmodule

FILE: sv/ads_parser.sv
// Length-type-data parser with UUID and manufacturer prefix compare.
module ads_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [7:0]        ad_byte,
  input  logic              last_byte,
  input  ads_pkg::cfg_t     cfg,
  output ads_pkg::flags_t   flags
);

  ads_pkg::phase_t phase_r, phase_nxt;
  ads_pkg::kind_t  kind_r, kind_nxt;
  logic [7:0] remaining_r, remaining_nxt;
  logic [3:0] elem_r, elem_nxt;
  logic [2:0] didx_r, didx_nxt;
  logic       req_r, req_nxt;
  logic       uuid_hit_r, uuid_hit_nxt;
  logic       mfr_hit_r, mfr_hit_nxt;

  logic [7:0] rem_dec;
  logic [2:0] pfx_len;
  logic [7:0] uuid_b;
  logic [7:0] mfr_b;
  logic       uuid_eq;
  logic       mfr_eq;

  assign rem_dec = remaining_r - 8'd1;
  assign pfx_len = (cfg.mfr_len > ads_pkg::MFR_MAX) ? ads_pkg::MFR_MAX : cfg.mfr_len;
  assign uuid_b  = cfg.uuid[{elem_r, 3'b000} +: 8];
  assign mfr_b   = (didx_r < ads_pkg::MFR_MAX) ? cfg.mfr_pattern[{didx_r, 3'b000} +: 8]
                                               : 8'h00;
  assign uuid_eq = req_r && (ad_byte == uuid_b);
  assign mfr_eq  = req_r && (ad_byte == mfr_b);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      ads_pkg::PH_LEN: begin
        if (ad_byte != 8'd0) phase_nxt = ads_pkg::PH_TYPE;
      end
      ads_pkg::PH_TYPE: begin
        phase_nxt = (rem_dec == 8'd0) ? ads_pkg::PH_LEN : ads_pkg::PH_DATA;
      end
      ads_pkg::PH_DATA: begin
        if (rem_dec == 8'd0) phase_nxt = ads_pkg::PH_LEN;
      end
      default: phase_nxt = ads_pkg::PH_LEN;
    endcase
  end

  // Counters, compare state and hit flags
  always_comb begin
    remaining_nxt = remaining_r;
    kind_nxt      = kind_r;
    elem_nxt      = elem_r;
    didx_nxt      = didx_r;
    req_nxt       = req_r;
    uuid_hit_nxt  = uuid_hit_r;
    mfr_hit_nxt   = mfr_hit_r;
    case (phase_r)
      ads_pkg::PH_LEN: begin
        if (ad_byte != 8'd0) remaining_nxt = ad_byte;
      end
      ads_pkg::PH_TYPE: begin
        remaining_nxt = rem_dec;
        elem_nxt      = 4'd0;
        didx_nxt      = 3'd0;
        req_nxt       = 1'b1;
        if (ad_byte == ads_pkg::TYPE_UUID128_MORE || ad_byte == ads_pkg::TYPE_UUID128_ALL) begin
          kind_nxt = ads_pkg::KIND_UUID;
        end else if (ad_byte == ads_pkg::TYPE_MFR) begin
          kind_nxt = ads_pkg::KIND_MFR;
          if (rem_dec == 8'd0 || pfx_len == 3'd0) mfr_hit_nxt = 1'b1;
        end else begin
          kind_nxt = ads_pkg::KIND_OTHER;
        end
      end
      ads_pkg::PH_DATA: begin
        remaining_nxt = rem_dec;
        case (kind_r)
          ads_pkg::KIND_UUID: begin
            // Close a UUID after sixteen bytes
            if (elem_r == 4'd15) begin
              if (uuid_eq) uuid_hit_nxt = 1'b1;
              req_nxt  = 1'b1;
              elem_nxt = 4'd0;
            end else begin
              req_nxt  = uuid_eq;
              elem_nxt = elem_r + 4'd1;
            end
          end
          ads_pkg::KIND_MFR: begin
            if (didx_r < pfx_len) begin
              req_nxt = mfr_eq;
              if (mfr_eq && ((didx_r + 3'd1) == pfx_len || rem_dec == 8'd0)) begin
                mfr_hit_nxt = 1'b1;
              end
            end
            // Saturate: only indexes below the prefix length matter
            if (didx_r != 3'd7) didx_nxt = didx_r + 3'd1;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Advance on each byte; clear after the final one
  always_ff @(posedge clk) begin
    if (!rst_n || (en && last_byte)) begin
      phase_r     <= ads_pkg::PH_LEN;
      kind_r      <= ads_pkg::KIND_OTHER;
      remaining_r <= '0;
      elem_r      <= '0;
      didx_r      <= '0;
      req_r       <= 1'b1;
      uuid_hit_r  <= 1'b0;
      mfr_hit_r   <= 1'b0;
    end else if (en) begin
      phase_r     <= phase_nxt;
      kind_r      <= kind_nxt;
      remaining_r <= remaining_nxt;
      elem_r      <= elem_nxt;
      didx_r      <= didx_nxt;
      req_r       <= req_nxt;
      uuid_hit_r  <= uuid_hit_nxt;
      mfr_hit_r   <= mfr_hit_nxt;
    end
  end

  assign flags.uuid_hit = uuid_hit_nxt;
  assign flags.mfr_hit  = mfr_hit_nxt;

  // A structure with no data bytes left never sits in the data phase
  a_data_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == ads_pkg::PH_DATA |-> remaining_r != 8'd0)
    else $error("data phase with zero bytes remaining");

  // The UUID hit flag, once set, holds until the final byte clears it
  a_uuid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    uuid_hit_r && !(en && last_byte) |=> uuid_hit_r)
    else $error("uuid hit dropped inside a payload");

  // The parser state is clear after a final byte
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    en && last_byte |=> phase_r == ads_pkg::PH_LEN && !uuid_hit_r && !mfr_hit_r)
    else $error("parser not cleared after final byte");

endmodule

FILE: sv/adv_data_service_filter.sv
// Top level of the advertising-data service filter.
//
// Usage: payload bytes enter on in_ad_byte with in_last_byte marking the final
// byte of one advertising payload, over a valid/ready channel. One result is
// given per payload on the out_ channel (out_found, out_uuid_seen,
// out_mfr_seen); bytes that are not final give no result.
// Configuration is written through cfg_we/cfg_index/cfg_wdata: index 0 and 1
// hold the 128-bit UUID, 2 the manufacturer prefix, 3 the prefix length.
// Throughput: one byte per cycle while no final byte is stalled; the parse and compare
// of a byte sit between the input register and the result register.
// Pipeline: two register stages; out_valid rises at the edge that moves the final
// byte out of the input register.
// Reset (synchronous, rst_n low) empties both stages, clears the parser and
// restores the register defaults.
// Stall: while a result waits on out_ready, non-final bytes keep flowing; a
// final byte waits in the input register, and in_ready falls only then.
module adv_data_service_filter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_ad_byte,
  input  logic                          in_last_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_found,
  output logic                          out_uuid_seen,
  output logic                          out_mfr_seen,
  input  logic                          cfg_we,
  input  logic [ads_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ads_pkg::CfgDataW-1:0]  cfg_wdata
);

  ads_pkg::cfg_t   cfg;
  ads_pkg::flags_t flags;

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       out_valid_r;
  logic       out_uuid_r;
  logic       out_mfr_r;
  logic       adv;

  ads_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ads_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .ad_byte   (in_byte_r),
    .last_byte (in_last_r),
    .cfg       (cfg),
    .flags     (flags)
  );

  // Advance the held byte unless it is final and the result slot is full and not being taken
  assign adv      = in_vld_r && (!in_last_r || !out_valid_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_ad_byte;
      in_last_r <= in_last_byte;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_last_r) begin
      out_uuid_r <= flags.uuid_hit;
      out_mfr_r  <= flags.mfr_hit;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_uuid_seen = out_uuid_r;
  assign out_mfr_seen  = out_mfr_r;
  assign out_found     = out_uuid_r && out_mfr_r;

  // Input stalls only behind a final byte that finds the result slot taken
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_vld_r && in_last_r && out_valid_r && !out_ready)
    else $error("input stalled without a blocked final byte");

  // A final byte that advances produces a result on the next cycle
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_last_r |=> out_valid_r)
    else $error("final byte gave no result");

  // A pending result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !(adv && in_last_r))
    else $error("result overwritten while stalled");

endmodule

FILE: verif/adv_data_service_filter_tb.sv
// Self-checking testbench for the advertising-data service filter.
`timescale 1ns / 100ps

module adv_data_service_filter_tb;
  import ads_pkg::*;

  // One payload byte as offered on the input channel
  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } pay_byte_t;

  // Flags expected at the end of one payload
  typedef struct packed {
    logic found;
    logic uuid_seen;
    logic mfr_seen;
  } verdict_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          in_ad_byte = 8'h00;
  logic                in_last_byte = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_found;
  logic                out_uuid_seen;
  logic                out_mfr_seen;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = CFG_UUID_LOW;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  pay_byte_t byte_q[$];
  verdict_t  verdict_q[$];
  int        errors = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  logic      in_fire = 1'b0;

  // Register copies kept alongside the block
  logic [63:0] reg_ulo = '0;
  logic [63:0] reg_uhi = '0;
  logic [47:0] reg_pat = MFR_PATTERN_RESET;
  logic [2:0]  reg_len = MFR_LEN_RESET;

  // Parser state of the predictor
  phase_t      ps_phase = PH_LEN;
  logic [7:0]  ps_rem = '0;
  logic [7:0]  ps_type = '0;
  logic [3:0]  ps_elem = '0;
  logic [7:0]  ps_didx = '0;
  logic        ps_run_eq = 1'b1;
  logic        ps_uuid_hit = 1'b0;
  logic        ps_mfr_hit = 1'b0;

  adv_data_service_filter DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_ad_byte   (in_ad_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_found    (out_found),
    .out_uuid_seen(out_uuid_seen),
    .out_mfr_seen (out_mfr_seen),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] uuid_at(logic [3:0] i);
    logic [127:0] u;
    u = {reg_uhi, reg_ulo};
    return u[i*8 +: 8];
  endfunction

  function automatic logic [7:0] pattern_at(int i);
    if (i >= MFR_MAX) return 8'h00;
    return reg_pat[i*8 +: 8];
  endfunction

  // Advance the parser by one accepted byte; on the final byte queue the flags
  task automatic parse_byte(input logic [7:0] b, input logic last);
    int unsigned n;
    logic        eq;
    n = (reg_len > MFR_MAX) ? MFR_MAX : reg_len;
    case (ps_phase)
      PH_LEN: begin
        if (b != 8'h00) begin
          ps_rem = b;
          ps_phase = PH_TYPE;
        end
      end
      PH_TYPE: begin
        ps_type = b;
        ps_rem = ps_rem - 8'd1;
        ps_elem = '0;
        ps_didx = '0;
        ps_run_eq = 1'b1;
        if (ps_type == TYPE_MFR && (ps_rem == 8'd0 || n == 0)) ps_mfr_hit = 1'b1;
        ps_phase = (ps_rem == 8'd0) ? PH_LEN : PH_DATA;
      end
      default: begin
        ps_rem = ps_rem - 8'd1;
        if (ps_type == TYPE_UUID128_MORE || ps_type == TYPE_UUID128_ALL) begin
          eq = ps_run_eq && (b == uuid_at(ps_elem));
          if (ps_elem == 4'd15) begin
            if (eq) ps_uuid_hit = 1'b1;
            ps_run_eq = 1'b1;
            ps_elem = '0;
          end else begin
            ps_run_eq = eq;
            ps_elem = ps_elem + 4'd1;
          end
        end else if (ps_type == TYPE_MFR) begin
          if (ps_didx < n) begin
            eq = ps_run_eq && (b == pattern_at(ps_didx));
            ps_run_eq = eq;
            if (eq && (ps_didx + 1 == n || ps_rem == 8'd0)) ps_mfr_hit = 1'b1;
          end
          if (ps_didx < 8'hFF) ps_didx = ps_didx + 8'd1;
        end
        if (ps_rem == 8'd0) ps_phase = PH_LEN;
      end
    endcase
    if (last) begin
      verdict_q.push_back('{found: ps_uuid_hit && ps_mfr_hit, uuid_seen: ps_uuid_hit,
                            mfr_seen: ps_mfr_hit});
      ps_phase = PH_LEN;
      ps_rem = '0;
      ps_type = '0;
      ps_elem = '0;
      ps_didx = '0;
      ps_run_eq = 1'b1;
      ps_uuid_hit = 1'b0;
      ps_mfr_hit = 1'b0;
    end
  endtask

  // Sample both channels: predict on input transactions, check output ones
  always @(posedge clk) begin
    verdict_t want;
    in_fire = rst_n && in_valid && in_ready;
    if (in_fire) parse_byte(in_ad_byte, in_last_byte);
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual found=%b uuid=%b mfr=%b",
                 $time, out_found, out_uuid_seen, out_mfr_seen);
      end else begin
        want = verdict_q.pop_front();
        if (out_found !== want.found) begin
          errors++;
          $display("%0t: found mismatch, expected %b, actual %b", $time, want.found, out_found);
        end
        if (out_uuid_seen !== want.uuid_seen) begin
          errors++;
          $display("%0t: uuid_seen mismatch, expected %b, actual %b", $time,
                   want.uuid_seen, out_uuid_seen);
        end
        if (out_mfr_seen !== want.mfr_seen) begin
          errors++;
          $display("%0t: mfr_seen mismatch, expected %b, actual %b", $time,
                   want.mfr_seen, out_mfr_seen);
        end
      end
    end
  end

  // Drive the next pending byte once the previous transaction has gone
  always @(negedge clk) begin
    pay_byte_t nxt;
    if (rst_n && (!in_valid || in_fire)) begin
      if (byte_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        nxt = byte_q.pop_front();
        in_valid <= 1'b1;
        in_ad_byte <= nxt.b;
        in_last_byte <= nxt.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
    if (rst_n) out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Write one register and mirror it in the predictor
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_UUID_LOW:    reg_ulo = val;
      CFG_UUID_HIGH:   reg_uhi = val;
      CFG_MFR_PATTERN: reg_pat = val[47:0];
      default:         reg_len = val[2:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Queue one payload, marking its final byte
  task automatic send_payload(input logic [7:0] pl[$]);
    for (int i = 0; i < pl.size(); i++)
      byte_q.push_back('{b: pl[i], last: (i == pl.size() - 1)});
  endtask

  // Hold until every byte is taken and every result has arrived, then settle
  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (byte_q.size() != 0 || in_valid || verdict_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Build random payloads, mostly well-formed structures, some noise and cuts
  task automatic random_bytes(input int n_bytes);
    int         added;
    int         nstruct;
    int         kind;
    int         k;
    int         extra;
    int         m;
    int         mut;
    logic       good;
    logic [7:0] pl[$];
    added = 0;
    while (added < n_bytes) begin
      pl.delete();
      nstruct = $urandom_range(1, 3);
      for (int s = 0; s < nstruct; s++) begin
        kind = $urandom_range(0, 9);
        case (kind)
          0: pl.push_back(8'h00);
          1, 2, 3: begin
            k = $urandom_range(1, 2);
            extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
            pl.push_back(8'(1 + 16 * k + extra));
            pl.push_back($urandom_range(0, 1) ? TYPE_UUID128_ALL : TYPE_UUID128_MORE);
            for (int u = 0; u < k; u++) begin
              good = ($urandom_range(0, 2) != 0);
              mut = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : -1;
              for (int j = 0; j < 16; j++) begin
                if (good)
                  pl.push_back(uuid_at(j[3:0]) ^ ((j == mut) ? 8'(1 << $urandom_range(0, 7))
                                                             : 8'h00));
                else
                  pl.push_back(8'($urandom));
              end
            end
            repeat (extra) pl.push_back(8'($urandom));
          end
          4, 5, 6: begin
            m = $urandom_range(0, 8);
            good = ($urandom_range(0, 3) != 0);
            mut = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 5) : -1;
            pl.push_back(8'(1 + m));
            pl.push_back(TYPE_MFR);
            for (int j = 0; j < m; j++) begin
              if (good && j < MFR_MAX)
                pl.push_back(pattern_at(j) ^ ((j == mut) ? 8'(1 << $urandom_range(0, 7))
                                                        : 8'h00));
              else
                pl.push_back(8'($urandom));
            end
          end
          7: begin
            m = $urandom_range(1, 6);
            pl.push_back(8'(m));
            repeat (m) pl.push_back(8'($urandom));
          end
          8: repeat ($urandom_range(1, 6)) pl.push_back(8'($urandom));
          default: begin
            // Oversized length, left to be cut off by the end of the payload
            pl.push_back(8'($urandom));
            case ($urandom_range(0, 3))
              0: pl.push_back(TYPE_UUID128_MORE);
              1: pl.push_back(TYPE_UUID128_ALL);
              2: pl.push_back(TYPE_MFR);
              default: pl.push_back(8'($urandom));
            endcase
            repeat ($urandom_range(0, 4)) pl.push_back(8'($urandom));
          end
        endcase
      end
      // Cut some payloads short at a random point
      if ($urandom_range(0, 4) == 0 && pl.size() > 1)
        pl = pl[0:$urandom_range(0, pl.size() - 2)];
      send_payload(pl);
      added += pl.size();
    end
  endtask

  // Timeout guard
  initial begin
    #(2_000_000);
    $display("Some tests failed");
    $finish;
  end

  // Sequence the run: reset, directed payloads, then random phases
  initial begin
    logic [7:0] pl[$];
    logic [63:0] pat_val;
    logic [2:0]  len_val;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Zero length skipped, empty prefix, whole UUID matched at reset values
    pl = '{8'h00, 8'h01, TYPE_MFR, 8'h11, TYPE_UUID128_ALL};
    repeat (16) pl.push_back(8'h00);
    send_payload(pl);
    // Final byte taken as a length byte
    pl = '{8'hFF};
    send_payload(pl);
    // Truncated manufacturer structure
    pl = '{8'h07, TYPE_MFR, 8'h0D};
    send_payload(pl);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        1: begin pat_val = '1; len_val = 3'd7; end
        2: begin pat_val = '0; len_val = 3'd0; end
        3: begin pat_val = {$urandom, $urandom}; len_val = 3'($urandom_range(1, 5)); end
        4: begin pat_val = {$urandom, $urandom}; len_val = 3'd7; end
        5: begin pat_val = {16'h0, MFR_PATTERN_RESET}; len_val = MFR_LEN_RESET; end
        6: begin pat_val = {$urandom, $urandom}; len_val = 3'd2; end
        default: begin pat_val = {$urandom, $urandom}; len_val = 3'($urandom_range(0, 7)); end
      endcase
      case (p)
        1: begin write_reg(CFG_UUID_LOW, '1); write_reg(CFG_UUID_HIGH, '1); end
        2: begin write_reg(CFG_UUID_LOW, '0); write_reg(CFG_UUID_HIGH, '0); end
        default: begin
          write_reg(CFG_UUID_LOW, {$urandom, $urandom});
          write_reg(CFG_UUID_HIGH, {$urandom, $urandom});
        end
      endcase
      write_reg(CFG_MFR_PATTERN, pat_val);
      write_reg(CFG_MFR_LEN, {$urandom, $urandom} & ~64'h7 | {61'h0, len_val});

      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 75; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 75; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase

      // Pause the sender mid-phase until every result is back
      random_bytes(50);
      drain();
      random_bytes(50);
      drain();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
